/* hdl/coil_write_frame_builder_assert.svh */
// Assertion macros shared by the frame builder checker.
// Depends on signals named clk and rst_n in the scope of each use.
`ifndef COIL_WRITE_FRAME_BUILDER_ASSERT_SVH
`define COIL_WRITE_FRAME_BUILDER_ASSERT_SVH

// Antecedent and consequent in the same cycle.
`define CWFB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CWFB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/cwfb_pkg.sv */
// Types and constants for the coil write frame builder.
// No dependencies; imported by every module of the block.
package cwfb_pkg;

  // One request word on the input channel.
  typedef struct packed {
    logic [7:0]  target_addr;
    logic [7:0]  channel;
    logic [7:0]  slave_addr;
    logic [15:0] coil_addr;
    logic [7:0]  coil_value;
    logic        read_ok;
  } in_word_t;

  // One frame byte on the output channel.
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } out_word_t;

  // Latched fields of one frame.
  typedef struct packed {
    logic [7:0]  target_addr;
    logic [7:0]  channel;
    logic [7:0]  slave_addr;
    logic [15:0] coil_addr;
    logic [7:0]  coil_value;
  } fields_t;

  // Handoff between the request register and the serializer.
  typedef struct packed {
    logic    valid;
    fields_t fields;
  } req_t;

  typedef logic [3:0] pos_t;

  // Byte positions within the frame.
  localparam pos_t POS_HEAD_HI = 4'd0;
  localparam pos_t POS_TARGET  = 4'd1;
  localparam pos_t POS_CHANNEL = 4'd2;
  localparam pos_t POS_SLAVE   = 4'd3;
  localparam pos_t POS_FUNC    = 4'd4;
  localparam pos_t POS_COIL_HI = 4'd5;
  localparam pos_t POS_COIL_LO = 4'd6;
  localparam pos_t POS_VALUE   = 4'd7;
  localparam pos_t POS_PAD     = 4'd8;
  localparam pos_t POS_CRC_LO  = 4'd9;
  localparam pos_t POS_CRC_HI  = 4'd10;
  localparam pos_t POS_LAST    = POS_CRC_HI;

  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [7:0]  FUNC_WRITE_COIL = 8'h05;
  localparam logic [7:0]  PAD_BYTE        = 8'h00;
  localparam logic [7:0]  HEAD_HI_BYTE    = 8'h00;

endpackage

/* hdl/coil_write_frame_builder.sv */
// Coil write frame builder: a request becomes an 11-byte radio-wrapped frame.
// Timing: an accepted request word is held in the request register; with the
// serializer idle it is taken and the first byte is loaded into the output register.
// One frame byte per cycle while out_stall is low, from the single output register;
// a new frame is taken as the last byte of the one before goes out, and a request with a failed read is dropped.
// Reset (synchronous, active low) empties the request and output registers.
module coil_write_frame_builder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cwfb_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output cwfb_pkg::out_word_t out_word
);
  import cwfb_pkg::*;

  req_t req;
  logic take;

  // Request register in front of the serializer.
  cwfb_req_reg u_req (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .take     (take),
    .req      (req)
  );

  // Byte serializer with the CRC and the output register.
  cwfb_serializer u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

/* hdl/cwfb_crc_step.sv */
// One-byte update of the CRC-16/Modbus register, eight bit steps.
// Depends on cwfb_pkg for the polynomial.
module cwfb_crc_step (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);
  import cwfb_pkg::*;

  // Reflected shift with conditional polynomial xor, once per data bit.
  always_comb begin
    logic [15:0] acc;
    acc = crc_in ^ {8'h00, data_in};
    for (int k = 0; k < 8; k++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ CRC_POLY;
      end else begin
        acc = acc >> 1;
      end
    end
    crc_out = acc;
  end

endmodule

/* hdl/cwfb_req_reg.sv */
// Request register: holds one accepted request until the serializer takes it.
// Depends on cwfb_pkg for the word and handoff types.
module cwfb_req_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cwfb_pkg::in_word_t  in_word,
  input  logic                take,
  output cwfb_pkg::req_t      req
);
  import cwfb_pkg::*;

  logic    hold_valid_r, hold_valid_nxt;
  fields_t hold_r;
  logic    accept;

  // A word is taken only while the register is empty.
  assign in_stall = hold_valid_r;
  assign accept   = in_valid && !hold_valid_r;

  // Requests with a failed read are dropped at the door.
  always_comb begin
    hold_valid_nxt = hold_valid_r && !take;
    if (accept && in_word.read_ok) begin
      hold_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r.target_addr <= in_word.target_addr;
      hold_r.channel     <= in_word.channel;
      hold_r.slave_addr  <= in_word.slave_addr;
      hold_r.coil_addr   <= in_word.coil_addr;
      hold_r.coil_value  <= in_word.coil_value;
    end
  end

  assign req.valid  = hold_valid_r;
  assign req.fields = hold_r;

endmodule

/* hdl/cwfb_serializer.sv */
// Frame serializer: byte counter, running CRC and the output register.
// Depends on cwfb_pkg and cwfb_crc_step.
module cwfb_serializer (
  input  logic                clk,
  input  logic                rst_n,
  input  cwfb_pkg::req_t      req,
  output logic                take,
  output logic                out_valid,
  input  logic                out_stall,
  output cwfb_pkg::out_word_t out_word
);
  import cwfb_pkg::*;

  logic        active_r, active_nxt;
  pos_t        idx_r, idx_nxt;
  fields_t     fields_r;
  logic [15:0] crc_r, crc_nxt;
  out_word_t   out_r, out_nxt;

  logic        advance;
  logic        at_last;
  logic        step;
  pos_t        idx_inc;
  logic [7:0]  step_byte;
  logic [15:0] crc_upd;
  logic        crc_covered;

  assign advance = !active_r || !out_stall;
  assign at_last = (idx_r == POS_LAST);
  assign take    = advance && (!active_r || at_last) && req.valid;
  assign step    = advance && active_r && !at_last;
  assign idx_inc = idx_r + 4'd1;

  // Byte that goes into the output register on a step.
  always_comb begin
    unique case (idx_inc)
      POS_HEAD_HI: step_byte = HEAD_HI_BYTE;
      POS_TARGET:  step_byte = fields_r.target_addr;
      POS_CHANNEL: step_byte = fields_r.channel;
      POS_SLAVE:   step_byte = fields_r.slave_addr;
      POS_FUNC:    step_byte = FUNC_WRITE_COIL;
      POS_COIL_HI: step_byte = fields_r.coil_addr[15:8];
      POS_COIL_LO: step_byte = fields_r.coil_addr[7:0];
      POS_VALUE:   step_byte = fields_r.coil_value;
      POS_PAD:     step_byte = PAD_BYTE;
      POS_CRC_LO:  step_byte = crc_r[7:0];
      POS_CRC_HI:  step_byte = crc_r[15:8];
      default:     step_byte = PAD_BYTE;
    endcase
  end

  // The CRC takes in the slave address through the pad byte.
  assign crc_covered = (idx_inc >= POS_SLAVE) && (idx_inc <= POS_PAD);

  cwfb_crc_step u_crc (
    .crc_in  (crc_r),
    .data_in (step_byte),
    .crc_out (crc_upd)
  );

  // Next state: load a new frame, step to the next byte, go idle, or hold while stalled.
  always_comb begin
    active_nxt = active_r;
    idx_nxt    = idx_r;
    crc_nxt    = crc_r;
    out_nxt    = out_r;
    if (take) begin
      active_nxt         = 1'b1;
      idx_nxt            = POS_HEAD_HI;
      crc_nxt            = CRC_INIT;
      out_nxt.frame_byte = HEAD_HI_BYTE;
      out_nxt.last_byte  = 1'b0;
    end else if (step) begin
      idx_nxt            = idx_inc;
      out_nxt.frame_byte = step_byte;
      out_nxt.last_byte  = (idx_inc == POS_LAST);
      if (crc_covered) begin
        crc_nxt = crc_upd;
      end
    end else if (advance) begin
      active_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= POS_HEAD_HI;
    end else begin
      active_r <= active_nxt;
      idx_r    <= idx_nxt;
    end
  end

  // Frame payload and CRC need no reset.
  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
    out_r <= out_nxt;
    if (take) begin
      fields_r <= req.fields;
    end
  end

  assign out_valid = active_r;
  assign out_word  = out_r;

endmodule

/* hdl/cwfb_checker.sv */
// Port-level checks on the frame builder, bound to the top level.
// Depends on cwfb_pkg and coil_write_frame_builder_assert.svh.
`include "coil_write_frame_builder_assert.svh"

module cwfb_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input cwfb_pkg::in_word_t  in_word,
  input logic                out_valid,
  input logic                out_stall,
  input cwfb_pkg::out_word_t out_word
);
  import cwfb_pkg::*;

  // A stalled output word stays put.
  `CWFB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "output word changed while stalled")

  // After a last byte goes out, either the line is idle or a new frame starts.
  `CWFB_ASSERT_NEXT(a_head_after_last, out_valid && !out_stall && out_word.last_byte, !out_valid || (out_word.frame_byte == HEAD_HI_BYTE && !out_word.last_byte), "frame did not start with the head byte")

  // A request with a failed read produces nothing.
  `CWFB_ASSERT_NEXT(a_drop_failed, in_valid && !in_stall && !in_word.read_ok && !out_valid, !out_valid, "failed read produced output")

  // A held request means a frame is in flight by the next cycle.
  `CWFB_ASSERT_NEXT(a_held_sends, in_stall, out_valid, "held request not being sent")

endmodule

bind coil_write_frame_builder cwfb_checker u_cwfb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
